// ----- rtl/core/fph_pkg.sv -----
// ----------------------------------------------------------------------------
// fph_pkg: shared types and constants of the fit policy heap allocator
// Table entry layout, cell command bus, status and state codes, heap sizing.
// ----------------------------------------------------------------------------
package fph_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int HEADER_BYTES   = 16;
  localparam int PAGE_BYTES     = 4096;
  localparam int HEAP_ADDR_BITS = 20;
  localparam int HEAP_RESET     = 65536;
  localparam int HEAP_CAP       = ((1 << HEAP_ADDR_BITS) / PAGE_BYTES) * PAGE_BYTES;
  localparam int IDX_BUS_W      = 10;
  localparam int CFG_W          = 20;
  localparam int SIZE_W         = 21;
  localparam int OUT_W          = 20;

  localparam logic       OP_ALLOC  = 1'b0;
  localparam logic       OP_FREE   = 1'b1;
  localparam logic [2:0] FIT_BEST  = 3'd0;
  localparam logic [2:0] FIT_WORST = 3'd1;
  localparam logic [2:0] FIT_FIRST = 3'd2;
  localparam logic [2:0] FIT_NEXT  = 3'd3;

  typedef logic [HEAP_ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t offset;
    addr_t size;
    logic  free;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_LOAD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [IDX_BUS_W-1:0] idx;
    entry_t               data;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_SPLIT,
    S_MARK,
    S_FSCAN,
    S_FEVAL,
    S_FMARK,
    S_DEL,
    S_WR,
    S_DONE
  } state_t;

  // Returns {table not empty, size of the single free block}.
  function automatic logic [HEAP_ADDR_BITS:0] init_block(input logic [CFG_W-1:0] hb);
    logic [21:0] want;
    logic [21:0] total;
    want = {2'b00, hb};
    if (want > 22'(HEAP_CAP - HEADER_BYTES)) want = 22'(HEAP_CAP - HEADER_BYTES);
    total = (want + 22'(HEADER_BYTES + PAGE_BYTES - 1)) & ~22'(PAGE_BYTES - 1);
    return {hb != '0, HEAP_ADDR_BITS'(total - 22'(HEADER_BYTES))};
  endfunction

endpackage

// ----- rtl/core/fph_req_if.sv -----
// ----------------------------------------------------------------------------
// fph_req_if: request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface fph_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [20:0] alloc_size;
  logic [2:0]  fit_policy;
  logic [19:0] free_offset;

  modport source(output valid, op, alloc_size, fit_policy, free_offset, input ready);
  modport sink(input valid, op, alloc_size, fit_policy, free_offset, output ready);
endinterface

// ----- rtl/core/fph_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fph_rsp_if: response channel
// Valid/ready channel carrying one status and payload offset.
// ----------------------------------------------------------------------------
interface fph_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] payload_offset;

  modport source(output valid, status, payload_offset, input ready);
  modport sink(input valid, status, payload_offset, output ready);
endinterface

// ----- rtl/core/fit_policy_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator: heap block allocator with four fit policies
// A row of table cells and a sequencer that allocates and frees heap blocks.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready); each gives one response on rsp
// with a status and, for a successful allocate, the payload offset.
// The block table lives in a row of MAX_BLOCKS cells. Every search rotates
// the whole row once past the sequencer, one entry per cycle.
// Allocate: a search, then a split when the remainder exceeds a header, and a
// mark; a malformed allocate answers without a search.
// Free: a search and a mark, then a delete and a write per neighbor merged;
// an unknown offset answers after the search.
// One request is in work at a time; the next is taken once the response is
// queued in the output register, so a waiting response does not block it.
// When the receiver stalls, the finished response holds on rsp and the
// sequencer waits at its end until the output register is free.
// Reset and a write on cfg_we rebuild the table as one free block sized from
// the heap size. The user must write cfg only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module fit_policy_heap_allocator #(
  parameter int MAX_BLOCKS = fph_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fph_pkg::CFG_W-1:0] cfg_wdata,
  fph_req_if.sink                   req,
  fph_rsp_if.source                 rsp
);
  import fph_pkg::*;

  entry_t    q [MAX_BLOCKS];
  cell_cmd_t cmd;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fph_cell #(.CELL_INDEX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (q[(i + MAX_BLOCKS - 1) % MAX_BLOCKS]),
      .right (q[(i + 1) % MAX_BLOCKS]),
      .q     (q[i])
    );
  end

  fph_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .head      (q[0]),
    .cmd       (cmd)
  );
endmodule

// ----- rtl/core/fph_cell.sv -----
// ----------------------------------------------------------------------------
// fph_cell: one block table entry
// Holds one entry and rotates, inserts or deletes with its neighbors.
// ----------------------------------------------------------------------------
module fph_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  fph_pkg::cell_cmd_t cmd,
  input  fph_pkg::entry_t    left,
  input  fph_pkg::entry_t    right,
  output fph_pkg::entry_t    q
);
  import fph_pkg::*;

  localparam logic [IDX_BUS_W-1:0] ME = IDX_BUS_W'(CELL_INDEX);

  entry_t q_next;

  always_comb begin
    q_next = q;
    case (cmd.op)
      CELL_ROTATE: q_next = right;
      CELL_LOAD:   if (ME == '0) q_next = cmd.data;
      CELL_WRITE:  if (ME == cmd.idx) q_next = cmd.data;
      CELL_INSERT: begin
        if (ME == cmd.idx) q_next = cmd.data;
        else if (ME > cmd.idx) q_next = left;
      end
      CELL_DELETE: if (ME >= cmd.idx) q_next = right;
      default:     q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule

// ----- rtl/core/fph_ctrl.sv -----
// ----------------------------------------------------------------------------
// fph_ctrl: allocator sequencer
// Scans the rotating cell row, picks blocks, splits, frees and merges.
// ----------------------------------------------------------------------------
module fph_ctrl #(
  parameter int MAX_BLOCKS = fph_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fph_pkg::CFG_W-1:0]  cfg_wdata,
  fph_req_if.sink                    req,
  fph_rsp_if.source                  rsp,
  input  fph_pkg::entry_t            head,
  output fph_pkg::cell_cmd_t         cmd
);
  import fph_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int KEY_W = CNT_W + 1;

  state_t state, state_next;

  logic [IDX_W-1:0]  pos, pick, lc, start, cur, del;
  logic [CNT_W-1:0]  count;
  logic              lcv, found, grab;
  logic              r_op;
  logic [SIZE_W-1:0] r_size;
  logic [2:0]        r_pol;
  logic [OUT_W-1:0]  r_foff;
  addr_t             pick_off, pick_size, mark_size, cur_off, cur_size;
  addr_t             prev_off, prev_size, l_off, l_size, nb_size;
  logic              prev_free, l_free, l_ok, nb_free, nb_ok;
  logic [KEY_W-1:0]  best_key;
  status_t           st;
  addr_t             payload;
  logic              rsp_valid;
  logic [1:0]        rsp_status;
  logic [OUT_W-1:0]  rsp_payload;

  logic [HEAP_ADDR_BITS:0] init_cfg, init_rst;
  logic                    accept, last_pos, head_live, head_fit, better, bad_alloc;
  logic [KEY_W-1:0]        key;
  addr_t                   rem;
  logic [CNT_W-1:0]        lc_plus;

  assign init_cfg  = init_block(cfg_wdata);
  assign init_rst  = init_block(CFG_W'(HEAP_RESET));
  assign accept    = req.valid && req.ready;
  assign last_pos  = pos == IDX_W'(MAX_BLOCKS - 1);
  assign head_live = CNT_W'(pos) < count;
  assign head_fit  = head_live && head.free && ({1'b0, head.size} >= r_size);
  assign key       = (pos >= start) ? KEY_W'(pos) - KEY_W'(start)
                                    : KEY_W'(pos) + KEY_W'(count) - KEY_W'(start);
  assign rem       = pick_size - HEAP_ADDR_BITS'(r_size);
  assign lc_plus   = CNT_W'(lc) + CNT_W'(1);
  assign bad_alloc = (req.fit_policy > FIT_NEXT) || (req.alloc_size == '0) || (count == '0);

  always_comb begin
    case (r_pol)
      FIT_BEST:  better = !found || (head.size < pick_size);
      FIT_WORST: better = !found || (head.size > pick_size);
      FIT_FIRST: better = !found;
      FIT_NEXT:  better = !found || (key < best_key);
      default:   better = 1'b0;
    endcase
  end

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.payload_offset = rsp_payload;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (req.op == OP_FREE) state_next = S_FSCAN;
        else if (bad_alloc) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN:  if (last_pos) state_next = S_EVAL;
      S_EVAL: begin
        if (!found) state_next = S_DONE;
        else if (rem > addr_t'(HEADER_BYTES))
          state_next = (count >= CNT_W'(MAX_BLOCKS)) ? S_DONE : S_SPLIT;
        else state_next = S_MARK;
      end
      S_SPLIT: state_next = S_MARK;
      S_MARK:  state_next = S_DONE;
      S_FSCAN: if (last_pos) state_next = S_FEVAL;
      S_FEVAL: state_next = found ? S_FMARK : S_DONE;
      S_FMARK: state_next = ((l_ok && l_free) || (nb_ok && nb_free)) ? S_DEL : S_DONE;
      S_DEL:   state_next = S_WR;
      S_WR:    state_next = (nb_ok && nb_free) ? S_DEL : S_DONE;
      S_DONE:  if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Cell commands.
  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.idx  = '0;
    cmd.data = '0;
    if (rst || cfg_we) begin
      cmd.op   = CELL_LOAD;
      cmd.data = '{offset: '0, size: rst ? init_rst[HEAP_ADDR_BITS-1:0]
                                         : init_cfg[HEAP_ADDR_BITS-1:0], free: 1'b1};
    end else begin
      case (state)
        S_SCAN, S_FSCAN: cmd.op = CELL_ROTATE;
        S_SPLIT: begin
          cmd.op   = CELL_INSERT;
          cmd.idx  = IDX_BUS_W'(pick) + IDX_BUS_W'(1);
          cmd.data = '{offset: pick_off + addr_t'(HEADER_BYTES) + addr_t'(r_size),
                       size: rem - addr_t'(HEADER_BYTES), free: 1'b1};
        end
        S_MARK: begin
          cmd.op   = CELL_WRITE;
          cmd.idx  = IDX_BUS_W'(pick);
          cmd.data = '{offset: pick_off, size: mark_size, free: 1'b0};
        end
        S_FMARK: begin
          cmd.op   = CELL_WRITE;
          cmd.idx  = IDX_BUS_W'(pick);
          cmd.data = '{offset: pick_off, size: pick_size, free: 1'b1};
        end
        S_DEL: begin
          cmd.op  = CELL_DELETE;
          cmd.idx = IDX_BUS_W'(del);
        end
        S_WR: begin
          cmd.op   = CELL_WRITE;
          cmd.idx  = IDX_BUS_W'(cur);
          cmd.data = '{offset: cur_off, size: cur_size, free: 1'b1};
        end
        default: cmd.op = CELL_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CNT_W'(init_rst[HEAP_ADDR_BITS]);
      lc        <= '0;
      lcv       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp.ready && state != S_DONE) rsp_valid <= 1'b0;
      if (cfg_we) begin
        count <= CNT_W'(init_cfg[HEAP_ADDR_BITS]);
        lc    <= '0;
        lcv   <= 1'b0;
      end
      case (state)
        S_IDLE: if (accept) begin
          r_op     <= req.op;
          r_size   <= req.alloc_size;
          r_pol    <= req.fit_policy;
          r_foff   <= req.free_offset;
          pos      <= '0;
          found    <= 1'b0;
          grab     <= 1'b0;
          nb_ok    <= 1'b0;
          l_ok     <= 1'b0;
          payload  <= '0;
          st       <= ST_NO_FIT;
          start    <= (req.fit_policy == FIT_NEXT && lcv && lc_plus < count)
                      ? IDX_W'(lc_plus) : '0;
        end
        S_SCAN: begin
          pos <= pos + IDX_W'(1);
          if (head_fit && better) begin
            found     <= 1'b1;
            pick      <= pos;
            pick_off  <= head.offset;
            pick_size <= head.size;
            best_key  <= key;
          end
        end
        S_EVAL: begin
          if (found && rem > addr_t'(HEADER_BYTES)) begin
            st <= ST_FULL;
            mark_size <= addr_t'(r_size);
          end else if (found) begin
            mark_size <= pick_size;
            lc        <= pick;
          end
        end
        S_SPLIT: begin
          count <= count + CNT_W'(1);
          lc    <= pick + IDX_W'(1);
        end
        S_MARK: begin
          lcv     <= 1'b1;
          st      <= ST_OK;
          payload <= pick_off + addr_t'(HEADER_BYTES);
        end
        S_FSCAN: begin
          pos       <= pos + IDX_W'(1);
          prev_off  <= head.offset;
          prev_size <= head.size;
          prev_free <= head.free;
          if (grab) begin
            nb_size <= head.size;
            nb_free <= head.free;
            grab    <= 1'b0;
          end
          if (!found && head_live &&
              (head.offset + addr_t'(HEADER_BYTES) == addr_t'(r_foff))) begin
            found     <= 1'b1;
            pick      <= pos;
            pick_off  <= head.offset;
            pick_size <= head.size;
            l_off     <= prev_off;
            l_size    <= prev_size;
            l_free    <= prev_free;
            l_ok      <= pos != '0;
            nb_ok     <= CNT_W'(pos) + CNT_W'(1) < count;
            grab      <= 1'b1;
          end
        end
        S_FEVAL: st <= found ? ST_OK : ST_UNKNOWN;
        S_FMARK: begin
          if (l_ok && l_free) begin
            cur      <= pick - IDX_W'(1);
            cur_off  <= l_off;
            cur_size <= l_size + pick_size + addr_t'(HEADER_BYTES);
            del      <= pick;
          end else begin
            cur      <= pick;
            cur_off  <= pick_off;
            cur_size <= pick_size + nb_size + addr_t'(HEADER_BYTES);
            del      <= pick + IDX_W'(1);
            nb_ok    <= 1'b0;
          end
        end
        S_DEL: begin
          count <= count - CNT_W'(1);
          if (lcv) begin
            if (lc == del) lc <= del - IDX_W'(1);
            else if (lc > del) lc <= lc - IDX_W'(1);
          end
        end
        S_WR: if (nb_ok && nb_free) begin
          cur_size <= cur_size + nb_size + addr_t'(HEADER_BYTES);
          del      <= cur + IDX_W'(1);
          nb_ok    <= 1'b0;
        end
        S_DONE: if (!rsp_valid || rsp.ready) begin
          rsp_valid   <= 1'b1;
          rsp_status  <= st;
          rsp_payload <= (st == ST_OK && r_op == OP_ALLOC) ? OUT_W'(payload) : '0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS)) else $error("block count above table depth");
  a_lc_range: assert property (@(posedge clk) disable iff (rst)
    (lcv && state == S_IDLE) |-> (CNT_W'(lc) < count)) else $error("last choice out of table");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && last_pos) |=> state == S_EVAL) else $error("scan overran");
  a_split_room: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> count < CNT_W'(MAX_BLOCKS)) else $error("split into full table");
`endif
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fit policy heap allocator
// A directed table of requests, then random allocate/free traffic, is checked
// against a table-based predictor with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import fph_pkg::*;

  localparam int TBL_DEPTH = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [19:0] offset;
    logic [20:0] size;
    bit          is_free;
  } heap_blk_t;

  typedef struct {
    bit          op;
    logic [20:0] alloc_size;
    logic [2:0]  fit_policy;
    logic [19:0] free_offset;
    bit          has_expect;
    status_t     exp_status;
    logic [19:0] exp_offset;
  } stim_row_t;

  typedef struct {
    status_t     status;
    logic [19:0] offset;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fph_req_if req_ch ();
  fph_rsp_if rsp_ch ();

  fit_policy_heap_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  heap_blk_t heap_map[TBL_DEPTH];
  int unsigned blk_count;
  int unsigned last_pick;
  bit last_pick_ok;
  heap_rsp_t pending_rsp[$];
  logic [19:0] live_offsets[$];
  int unsigned mismatch_count = 0;
  int unsigned rsp_count = 0;
  int unsigned cycle_count = 0;
  bit rx_hold = 1'b0;
  bit calm_phase = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = 1'b0;
    req_ch.alloc_size = '0;
    req_ch.fit_policy = '0;
    req_ch.free_offset = '0;
    rsp_ch.ready = 1'b0;
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (response %0d)", what, got, want, rsp_count);
    mismatch_count++;
  endtask

  function automatic void heap_rebuild(input logic [19:0] hb);
    int unsigned want;
    int unsigned total;
    last_pick = 0;
    last_pick_ok = 1'b0;
    blk_count = 0;
    if (hb == 0) return;
    want = hb;
    if (want > HEAP_CAP - HEADER_BYTES) want = HEAP_CAP - HEADER_BYTES;
    total = ((want + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    heap_map[0].offset = '0;
    heap_map[0].size = 21'(total - HEADER_BYTES);
    heap_map[0].is_free = 1'b1;
    blk_count = 1;
  endfunction

  function automatic heap_rsp_t heap_alloc(input logic [20:0] sz, input logic [2:0] pol);
    heap_rsp_t r;
    int unsigned i, k, pick, start;
    bit found;
    int unsigned rem;
    r.status = ST_NO_FIT;
    r.offset = '0;
    pick = 0;
    start = 0;
    found = 1'b0;
    if (pol > FIT_NEXT || sz == 0 || blk_count == 0) return r;
    if (pol == FIT_NEXT && last_pick_ok && last_pick + 1 < blk_count) start = last_pick + 1;
    for (k = 0; k < blk_count; k++) begin
      i = (start + k) % blk_count;
      if (!heap_map[i].is_free || heap_map[i].size < sz) continue;
      if (pol == FIT_BEST) begin
        if (!found || heap_map[i].size < heap_map[pick].size) begin
          pick = i;
          found = 1'b1;
        end
      end else if (pol == FIT_WORST) begin
        if (!found || heap_map[i].size > heap_map[pick].size) begin
          pick = i;
          found = 1'b1;
        end
      end else begin
        pick = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) return r;
    rem = heap_map[pick].size - sz;
    if (rem > HEADER_BYTES) begin
      if (blk_count >= TBL_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      for (i = blk_count; i > pick + 1; i--) heap_map[i] = heap_map[i-1];
      heap_map[pick+1].offset = 20'(heap_map[pick].offset + HEADER_BYTES + sz);
      heap_map[pick+1].size = 21'(rem - HEADER_BYTES);
      heap_map[pick+1].is_free = 1'b1;
      blk_count++;
      heap_map[pick].size = sz;
      last_pick = pick + 1;
    end else begin
      last_pick = pick;
    end
    last_pick_ok = 1'b1;
    heap_map[pick].is_free = 1'b0;
    r.status = ST_OK;
    r.offset = 20'(heap_map[pick].offset + HEADER_BYTES);
    return r;
  endfunction

  function automatic heap_rsp_t heap_free(input logic [19:0] off);
    heap_rsp_t r;
    int unsigned i, j;
    bit found;
    r.status = ST_UNKNOWN;
    r.offset = '0;
    found = 1'b0;
    for (i = 0; i < blk_count; i++) begin
      if (heap_map[i].offset + HEADER_BYTES == off) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) return r;
    heap_map[i].is_free = 1'b1;
    j = 0;
    while (j + 1 < blk_count) begin
      if (heap_map[j].is_free && heap_map[j+1].is_free) begin
        heap_map[j].size = 21'(heap_map[j].size + heap_map[j+1].size + HEADER_BYTES);
        for (i = j + 1; i + 1 < blk_count; i++) heap_map[i] = heap_map[i+1];
        blk_count--;
        if (last_pick_ok) begin
          if (last_pick == j + 1) last_pick = j;
          else if (last_pick > j + 1) last_pick--;
        end
      end else begin
        j++;
      end
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Sends one request, waits for acceptance and queues what it should return.
  // Valid stays high after acceptance until the next request or a drain.
  task automatic send_request(input stim_row_t row);
    heap_rsp_t r;
    int unsigned gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= row.op;
    req_ch.alloc_size <= row.alloc_size;
    req_ch.fit_policy <= row.fit_policy;
    req_ch.free_offset <= row.free_offset;
    do @(posedge clk); while (!req_ch.ready);
    if (row.op == OP_ALLOC) r = heap_alloc(row.alloc_size, row.fit_policy);
    else r = heap_free(row.free_offset);
    if (row.has_expect && (r.status != row.exp_status || r.offset != row.exp_offset))
      report("directed row vs predictor", r.status, row.exp_status);
    if (r.status == ST_OK && row.op == OP_ALLOC) live_offsets.push_back(r.offset);
    pending_rsp.push_back(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_heap(input logic [19:0] hb);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= hb;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_rebuild(hb);
    live_offsets.delete();
  endtask

  function automatic stim_row_t mk(input bit op, input int unsigned sz, input int unsigned pol,
                                   input int unsigned off, input bit chk,
                                   input status_t st, input int unsigned eoff);
    stim_row_t s;
    s.op = op;
    s.alloc_size = 21'(sz);
    s.fit_policy = 3'(pol);
    s.free_offset = 20'(off);
    s.has_expect = chk;
    s.exp_status = st;
    s.exp_offset = 20'(eoff);
    return s;
  endfunction

  function automatic stim_row_t rand_row(input bit sane);
    stim_row_t s;
    int unsigned pick;
    s.has_expect = 1'b0;
    s.exp_status = ST_OK;
    s.exp_offset = '0;
    s.alloc_size = 21'($urandom_range(1, 3000));
    s.fit_policy = 3'($urandom_range(0, 3));
    s.free_offset = 20'($urandom);
    s.op = (live_offsets.size() > 0 && $urandom_range(0, 1)) ? OP_FREE : OP_ALLOC;
    if (s.op == OP_FREE && live_offsets.size() > 0) begin
      pick = $urandom_range(0, live_offsets.size() - 1);
      s.free_offset = live_offsets[pick];
      live_offsets.delete(pick);
    end
    if (!sane) begin
      case ($urandom_range(0, 4))
        0: s.alloc_size = 21'($urandom);
        1: s.fit_policy = 3'($urandom_range(4, 7));
        2: s.alloc_size = 21'($urandom_range(0, 32));
        3: s.free_offset = 20'($urandom);
        default: s.alloc_size = 21'h1FFFFF;
      endcase
    end
    s.alloc_size = s.alloc_size & 21'h1FFFFF;
    return s;
  endfunction

  // Response side: random ready bursts, plus one long hold-off.
  initial begin
    int unsigned burst;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      burst = $urandom_range(1, 11);
      if (rx_hold) begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    heap_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected response status", rsp_ch.status, 0);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_ch.status != e.status) report("status", rsp_ch.status, e.status);
        if (rsp_ch.payload_offset != e.offset)
          report("payload_offset", rsp_ch.payload_offset, e.offset);
      end
      rsp_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    int unsigned n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    heap_rebuild(20'(HEAP_RESET));
    @(posedge clk);

    // Directed: reset heap is one 69616-byte free block at offset 0.
    dir_rows.push_back(mk(OP_ALLOC, 0, FIT_BEST, 0, 1, ST_NO_FIT, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16, 3'd4, 0, 1, ST_NO_FIT, 0));
    dir_rows.push_back(mk(OP_ALLOC, 16, 3'd7, 0, 1, ST_NO_FIT, 0));
    dir_rows.push_back(mk(OP_ALLOC, 21'h1FFFFF, FIT_FIRST, 0, 1, ST_NO_FIT, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 0, 20'hFFFFF, 1, ST_UNKNOWN, 0));
    dir_rows.push_back(mk(OP_ALLOC, 100, FIT_BEST, 0, 1, ST_OK, 16));
    dir_rows.push_back(mk(OP_ALLOC, 200, FIT_WORST, 0, 0, ST_OK, 0));
    dir_rows.push_back(mk(OP_ALLOC, 300, FIT_FIRST, 0, 0, ST_OK, 0));
    dir_rows.push_back(mk(OP_ALLOC, 50, FIT_NEXT, 0, 0, ST_OK, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 0, 16, 1, ST_OK, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 0, 16, 1, ST_OK, 0));
    dir_rows.push_back(mk(OP_ALLOC, 90, FIT_BEST, 0, 0, ST_OK, 0));
    dir_rows.push_back(mk(OP_FREE, 0, 0, 0, 1, ST_UNKNOWN, 0));
    dir_rows.push_back(mk(OP_ALLOC, 1, FIT_NEXT, 0, 0, ST_OK, 0));
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // Small remainder: whole block handed out, then the table fills up.
    write_heap(20'd1);
    send_request(mk(OP_ALLOC, 4070, FIT_FIRST, 0, 1, ST_OK, 16));
    send_request(mk(OP_FREE, 0, 0, 16, 1, ST_OK, 0));
    send_request(mk(OP_ALLOC, 4080, FIT_WORST, 0, 1, ST_OK, 16));
    write_heap(20'd0);
    send_request(mk(OP_ALLOC, 1, FIT_BEST, 0, 1, ST_NO_FIT, 0));
    send_request(mk(OP_FREE, 0, 0, 16, 1, ST_UNKNOWN, 0));
    write_heap(20'hFFFFF);
    send_request(mk(OP_ALLOC, 21'h100000, FIT_BEST, 0, 1, ST_NO_FIT, 0));
    send_request(mk(OP_ALLOC, 1048560, FIT_WORST, 0, 1, ST_OK, 16));
    write_heap(20'd60000);
    for (n = 0; n < 70; n++) send_request(mk(OP_ALLOC, 20, FIT_FIRST, 0, 0, ST_OK, 0));

    // Long receiver stall while requests keep coming.
    write_heap(20'd200000);
    rx_hold = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (n = 0; n < 12; n++) send_request(rand_row(1'b1));
    join

    for (n = 0; n < 1400; n++) begin
      if (n % 350 == 0) begin
        case (n / 350)
          0: write_heap(20'd30000);
          1: write_heap(20'd8000);
          2: write_heap(20'hFFFFF);
          default: write_heap(20'($urandom_range(1, 1048560)));
        endcase
      end
      if (n == 1200) calm_phase = 1'b1;
      send_request(rand_row($urandom_range(0, 9) != 0));
    end

    drain();
    $display("Covered %0d responses over several heap sizes, all four fit policies,",
             rsp_count);
    $display("bad requests, unknown frees, full table and a long response stall.");
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
